[rtl/core/dsdre_pkg.sv]
// Shared types and constants for the DSD range encoder.
package dsdre_pkg;

  localparam logic [2:0] REQ_ENCODE = 3'd0;
  localparam logic [2:0] REQ_START  = 3'd1;
  localparam logic [2:0] REQ_FLUSH  = 3'd2;
  localparam logic [2:0] REQ_TWRITE = 3'd3;
  localparam logic [2:0] REQ_TREAD  = 3'd4;

  localparam int USE_BITS = 12;
  localparam int MUL_AW   = 25;
  localparam int MUL_BW   = 17;
  localparam int MUL_PW   = MUL_AW + MUL_BW;

  localparam logic signed [26:0] P_UP       = 27'sh10000fe;
  localparam logic signed [26:0] P_DOWN     = 27'sh0010000;
  localparam logic signed [17:0] DECAY_BIAS = 18'sd512;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
    logic [7:0]  table_index;
    logic [24:0] table_value;
  } in_t;

  typedef struct packed {
    logic [7:0]  code_byte;
    logic [24:0] read_value;
    logic        last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PRED,
    ST_READ,
    ST_SPAN,
    ST_UPD,
    ST_SHIFT,
    ST_DECAY,
    ST_HDR,
    ST_TRD,
    ST_TDATA,
    ST_FLUSH,
    ST_DONE
  } state_e;

endpackage

[rtl/core/dsd_bit_predictive_range_encoder.sv]
// Top level: sequencer and datapath of the DSD bit predictive range encoder.
// Each coded bit steps through PRED, READ, SPAN, UPD and SHIFT, with a further SHIFT step per
// emitted byte; an encode beat codes 8 bits mono or 16 stereo, then runs DECAY and DONE.
// A start block emits seven header bytes per channel; a flush copies low to high, then shifts.
// Results leave through a one-deep hold stage and an output register; output stalls add cycles.
// Reset is asynchronous; the table holds no defined contents until written.
module dsd_bit_predictive_range_encoder #(
  parameter int TABLE_BITS       = 8,
  parameter int FILTER_PRECISION = 20
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dsdre_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dsdre_pkg::out_t   out_data_o
);

  localparam int TB = TABLE_BITS;
  localparam int FW = FILTER_PRECISION + 1;
  localparam int DW = FILTER_PRECISION - 2;
  localparam int SW = FW + 2;
  localparam int QS = FILTER_PRECISION - 8;
  localparam int IS = FILTER_PRECISION - dsdre_pkg::USE_BITS;
  localparam int PW = dsdre_pkg::MUL_PW;
  localparam logic signed [SW-1:0] OneS = SW'(64'd1 << FILTER_PRECISION);
  localparam logic [FW-1:0] HalfF = FW'(64'd1 << (FILTER_PRECISION - 1));

  dsdre_pkg::state_e state_q, state_d;

  logic              stereo_q;
  logic [2:0]        req_q;
  logic [7:0]        b0_q, b1_q;
  logic [3:0]        cnt_q;
  logic              ch_q;
  logic [2:0]        hk_q;
  logic [TB-1:0]     tidx_q, idx_q;
  logic [31:0]       high_q, low_q;
  logic [FW-1:0]     f_q [2][5];
  logic signed [DW-1:0] dl_q [2];
  logic signed [15:0]   ff_q [2];
  logic              bit_q, fb_en_q, fb_dec_q;
  logic [24:0]       p_q;

  logic              pend_valid_q, out_valid_q;
  logic [7:0]        pend_byte_q;
  logic [24:0]       pend_word_q;
  dsdre_pkg::out_t   out_q;

  logic              push, pop, can_out, can_push, top_eq, last_bit, accept;
  logic [7:0]        res_byte, hdr_byte;
  logic [24:0]       res_word;

  logic signed [dsdre_pkg::MUL_AW-1:0] mul_a;
  logic signed [dsdre_pkg::MUL_BW-1:0] mul_b;
  logic signed [PW-1:0]                prod;

  logic [24:0]       ram_rdata;
  logic              ram_we, ram_re;
  logic [TB-1:0]     ram_waddr, ram_raddr;
  logic [24:0]       ram_wdata;

  logic signed [PW-1:0] v_w, a_w, b_w, dl_w;
  logic [TB-1:0]        v_idx;
  logic                 cur_bit;

  logic signed [SW-1:0] e0, e1, e2, e3, e4, n0, n1, n2, n3, n4, d_s, dl_e, dl_n;
  logic signed [26:0]   pe, pn;
  logic [31:0]          span;
  logic signed [17:0]   x0, x1, nx0, nx1;

  assign accept   = in_valid_i && !in_stall_o;
  assign can_out  = !out_valid_q || !out_stall_i;
  assign can_push = !pend_valid_q || can_out;
  assign top_eq   = high_q[31:24] == low_q[31:24];
  assign last_bit = cnt_q == (stereo_q ? 4'd15 : 4'd7);
  assign cur_bit  = ch_q ? b1_q[7] : b0_q[7];

  always_comb begin
    case (hk_q)
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4: hdr_byte = f_q[ch_q][hk_q][QS +: 8];
      3'd5:    hdr_byte = ff_q[ch_q][7:0];
      3'd6:    hdr_byte = ff_q[ch_q][15:8];
      default: hdr_byte = 8'd0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    push     = 1'b0;
    pop      = 1'b0;
    res_byte = high_q[31:24];
    res_word = '0;
    case (state_q)
      dsdre_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data_i.req_type)
            dsdre_pkg::REQ_ENCODE: state_d = dsdre_pkg::ST_PRED;
            dsdre_pkg::REQ_START:  state_d = dsdre_pkg::ST_HDR;
            dsdre_pkg::REQ_FLUSH:  state_d = dsdre_pkg::ST_FLUSH;
            dsdre_pkg::REQ_TREAD:  state_d = dsdre_pkg::ST_TRD;
            default:               state_d = dsdre_pkg::ST_DONE;
          endcase
        end
      end
      dsdre_pkg::ST_PRED:  state_d = dsdre_pkg::ST_READ;
      dsdre_pkg::ST_READ:  state_d = dsdre_pkg::ST_SPAN;
      dsdre_pkg::ST_SPAN:  state_d = dsdre_pkg::ST_UPD;
      dsdre_pkg::ST_UPD:   state_d = dsdre_pkg::ST_SHIFT;
      dsdre_pkg::ST_SHIFT: begin
        if (top_eq) begin
          push = can_push;
        end else if (req_q == dsdre_pkg::REQ_ENCODE) begin
          state_d = last_bit ? dsdre_pkg::ST_DECAY : dsdre_pkg::ST_PRED;
        end else begin
          state_d = dsdre_pkg::ST_DONE;
        end
      end
      dsdre_pkg::ST_DECAY: state_d = dsdre_pkg::ST_DONE;
      dsdre_pkg::ST_HDR: begin
        push     = can_push;
        res_byte = hdr_byte;
        if (can_push && hk_q == 3'd6 && (ch_q || !stereo_q)) begin
          state_d = dsdre_pkg::ST_DONE;
        end
      end
      dsdre_pkg::ST_TRD:   state_d = dsdre_pkg::ST_TDATA;
      dsdre_pkg::ST_TDATA: begin
        push     = can_push;
        res_byte = 8'd0;
        res_word = ram_rdata;
        if (can_push) begin
          state_d = dsdre_pkg::ST_DONE;
        end
      end
      dsdre_pkg::ST_FLUSH: state_d = dsdre_pkg::ST_SHIFT;
      dsdre_pkg::ST_DONE: begin
        if (!pend_valid_q) begin
          state_d = dsdre_pkg::ST_IDLE;
        end else if (can_out) begin
          pop     = 1'b1;
          state_d = dsdre_pkg::ST_IDLE;
        end
      end
      default: state_d = dsdre_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    if (state_q == dsdre_pkg::ST_PRED) begin
      mul_a = dsdre_pkg::MUL_AW'(dl_q[ch_q]);
      mul_b = dsdre_pkg::MUL_BW'(ff_q[ch_q]);
    end else begin
      mul_a = $signed({1'b0, 24'((high_q - low_q) >> 8)});
      mul_b = $signed({8'd0, ram_rdata[24:16]});
    end
  end

  dsdre_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  assign dl_w  = PW'(dl_q[ch_q]);
  assign v_w   = $signed(PW'(f_q[ch_q][0])) - $signed(PW'(f_q[ch_q][4])) + (prod >>> 2);
  assign a_w   = v_w + (dl_w <<< 3);
  assign b_w   = v_w - (dl_w <<< 3);
  assign v_idx = v_w[IS +: TB];

  assign e0   = $signed(SW'(f_q[ch_q][0]));
  assign e1   = $signed(SW'(f_q[ch_q][1]));
  assign e2   = $signed(SW'(f_q[ch_q][2]));
  assign e3   = $signed(SW'(f_q[ch_q][3]));
  assign e4   = $signed(SW'(f_q[ch_q][4]));
  assign dl_e = SW'(dl_q[ch_q]);
  assign n0   = e0 + ((bit_q ? OneS - e0 : -e0) >>> 6);
  assign n1   = e1 + ((bit_q ? OneS - e1 : -e1) >>> 4);
  assign n2   = e2 + ((n1 - e2) >>> 4);
  assign n3   = e3 + ((n2 - e3) >>> 4);
  assign d_s  = (n3 - e4) >>> 4;
  assign n4   = e4 + d_s;
  assign dl_n = dl_e + ((d_s - dl_e) >>> 3);

  assign pe   = $signed({2'b00, p_q});
  assign pn   = pe + (((bit_q ? dsdre_pkg::P_UP : dsdre_pkg::P_DOWN) - pe) >>> 8);
  assign span = prod[31:0];

  assign x0  = 18'(ff_q[0]);
  assign x1  = 18'(ff_q[1]);
  assign nx0 = x0 - ((x0 + dsdre_pkg::DECAY_BIAS) >>> 10);
  assign nx1 = x1 - ((x1 + dsdre_pkg::DECAY_BIAS) >>> 10);

  assign ram_we    = (accept && in_data_i.req_type == dsdre_pkg::REQ_TWRITE) ||
                     state_q == dsdre_pkg::ST_UPD;
  assign ram_waddr = (state_q == dsdre_pkg::ST_UPD) ? idx_q : TB'(in_data_i.table_index);
  assign ram_wdata = (state_q == dsdre_pkg::ST_UPD) ? pn[24:0] : in_data_i.table_value;
  assign ram_re    = state_q == dsdre_pkg::ST_READ || state_q == dsdre_pkg::ST_TRD;
  assign ram_raddr = (state_q == dsdre_pkg::ST_READ) ? v_idx : tidx_q;

  dsdre_prob_ram #(
    .ADDR_W (TB)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dsdre_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stereo_q <= 1'b0;
      req_q    <= dsdre_pkg::REQ_ENCODE;
      cnt_q    <= '0;
      ch_q     <= 1'b0;
      hk_q     <= '0;
      high_q   <= 32'hffff_ffff;
      low_q    <= '0;
      for (int c = 0; c < 2; c++) begin
        for (int k = 0; k < 5; k++) begin
          f_q[c][k] <= HalfF;
        end
        dl_q[c] <= '0;
        ff_q[c] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        stereo_q <= cfg_wdata_i;
      end
      case (state_q)
        dsdre_pkg::ST_IDLE: begin
          if (accept) begin
            req_q <= in_data_i.req_type;
            cnt_q <= '0;
            ch_q  <= 1'b0;
            hk_q  <= '0;
            if (in_data_i.req_type == dsdre_pkg::REQ_START) begin
              high_q <= 32'hffff_ffff;
              low_q  <= '0;
            end
          end
        end
        dsdre_pkg::ST_UPD: begin
          if (bit_q) begin
            high_q <= low_q + span;
          end else begin
            low_q <= low_q + 32'd1 + span;
          end
          f_q[ch_q][0] <= n0[FW-1:0];
          f_q[ch_q][1] <= n1[FW-1:0];
          f_q[ch_q][2] <= n2[FW-1:0];
          f_q[ch_q][3] <= n3[FW-1:0];
          f_q[ch_q][4] <= n4[FW-1:0];
          dl_q[ch_q]   <= dl_n[DW-1:0];
          if (fb_en_q) begin
            ff_q[ch_q] <= fb_dec_q ? ff_q[ch_q] - 16'sd1 : ff_q[ch_q] + 16'sd1;
          end
        end
        dsdre_pkg::ST_SHIFT: begin
          if (top_eq) begin
            if (can_push) begin
              high_q <= {high_q[23:0], 8'hff};
              low_q  <= {low_q[23:0], 8'h00};
            end
          end else if (req_q == dsdre_pkg::REQ_ENCODE && !last_bit) begin
            cnt_q <= cnt_q + 4'd1;
            ch_q  <= stereo_q ? !ch_q : 1'b0;
          end
        end
        dsdre_pkg::ST_DECAY: begin
          ff_q[0] <= nx0[15:0];
          if (stereo_q) begin
            ff_q[1] <= nx1[15:0];
          end
        end
        dsdre_pkg::ST_HDR: begin
          if (can_push) begin
            if (hk_q < 3'd5) begin
              f_q[ch_q][hk_q] <= FW'(hdr_byte) << QS;
            end
            if (hk_q == 3'd6) begin
              dl_q[ch_q] <= '0;
              hk_q       <= '0;
              ch_q       <= 1'b1;
            end else begin
              hk_q <= hk_q + 3'd1;
            end
          end
        end
        dsdre_pkg::ST_FLUSH: high_q <= low_q;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      b0_q   <= in_data_i.first_byte;
      b1_q   <= in_data_i.second_byte;
      tidx_q <= TB'(in_data_i.table_index);
    end
    if (state_q == dsdre_pkg::ST_READ) begin
      idx_q    <= v_idx;
      bit_q    <= cur_bit;
      fb_en_q  <= a_w[31] ^ b_w[31];
      fb_dec_q <= a_w[31] ^ cur_bit;
    end
    if (state_q == dsdre_pkg::ST_SPAN) begin
      p_q <= ram_rdata;
    end
    if (state_q == dsdre_pkg::ST_UPD) begin
      if (ch_q) begin
        b1_q <= {b1_q[6:0], 1'b0};
      end else begin
        b0_q <= {b0_q[6:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (push) begin
        pend_valid_q <= 1'b1;
        out_valid_q  <= pend_valid_q || (out_valid_q && out_stall_i);
      end else if (pop) begin
        pend_valid_q <= 1'b0;
        out_valid_q  <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      pend_byte_q <= res_byte;
      pend_word_q <= res_word;
    end
    if ((push && pend_valid_q) || pop) begin
      out_q.code_byte  <= pend_byte_q;
      out_q.read_value <= pend_word_q;
      out_q.last       <= pop;
    end
  end

  assign in_stall_o  = state_q != dsdre_pkg::ST_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsdre_pkg::ST_IDLE |-> !pend_valid_q)
    else $error("hold stage not empty while idle");

  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push || pop) |-> (pend_valid_q ? can_out : push))
    else $error("result moved without room");

  a_upd_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == dsdre_pkg::ST_UPD |=> state_q == dsdre_pkg::ST_SHIFT)
    else $error("bit update not followed by byte shift");

endmodule

[rtl/core/dsdre_prob_ram.sv]
// Probability table memory with one write port and one registered read port.
module dsdre_prob_ram #(
  parameter int ADDR_W = 8
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [24:0]       wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [24:0]       rdata_o
);

  logic [24:0] mem_q [2**ADDR_W];
  logic [24:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/dsdre_mul.sv]
// Shared signed multiplier with a registered product.
module dsdre_mul (
  input  logic                                clk_i,
  input  logic signed [dsdre_pkg::MUL_AW-1:0] a_i,
  input  logic signed [dsdre_pkg::MUL_BW-1:0] b_i,
  output logic signed [dsdre_pkg::MUL_PW-1:0] prod_o
);

  logic signed [dsdre_pkg::MUL_PW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= a_i * b_i;
  end

  assign prod_o = prod_q;

endmodule
